// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the list core
// used by birl_ctrl and bounded_insert_remove_list_top; expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BIRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BIRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/birl_pkg.sv =====
// shared types and constants of the bounded list core
// no dependencies; imported by birl_cell, birl_ctrl and the top level
package birl_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 32;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 6;
    localparam int MODE_W     = 2;
    localparam int ST_W       = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT,
        MODE_REMOVE,
        MODE_READ,
        MODE_CLEAR
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_BAD_POS,
        ST_FULL,
        ST_EMPTY
    } t_status;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             acc;
        logic             ins;
        logic             rem;
        logic             rd;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

    // per-request result fields other than the read data
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
    } t_resp;

endpackage

// ===== rtl/core/bounded_insert_remove_list_top.sv =====
// channel  direction  handshake            payload
// in       input      i_in_valid/o_in_stall  i_mode, i_position, i_value_in
// out      output     o_out_valid/i_out_stall o_status, o_read_value, o_entry_count,
//                                             o_is_full, o_is_empty
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (capacity)
//
// one word per cycle while i_out_stall is low; a tap stage, then the output register
// the cells shift the entries at and above the position in the accept cycle, a read
// is held in the cell taps and merged into the output register when it advances
// synchronous active-low reset clears count, capacity (to 64) and the handshake state
// an output stall holds one word in the tap stage, then stalls the input
// depends on birl_pkg, birl_cell, birl_ctrl and assert_macros.svh
`include "assert_macros.svh"

module bounded_insert_remove_list_top
    import birl_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CNT_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [MODE_W-1:0]            i_mode,
    input  logic [POS_W-1:0]             i_position,
    input  logic signed [DATA_WIDTH-1:0] i_value_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ST_W-1:0]              o_status,
    output logic signed [DATA_WIDTH-1:0] o_read_value,
    output logic [CNT_W-1:0]             o_entry_count,
    output logic                         o_is_full,
    output logic                         o_is_empty
);

    t_cell_ctl             w_ctl;
    t_resp                 w_resp;
    logic                  w_accept;
    logic                  w_adv;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd;

    logic                  r_pend;
    logic                  n_pend;
    t_resp                 r_p_resp;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_resp                 r_out_resp;
    logic [DATA_WIDTH-1:0] r_out_rd;

    // handshake
    assign o_cfg_ready = 1'b1;
    assign w_adv       = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_pend && r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;

    birl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_mode     (i_mode),
        .i_position (i_position),
        .o_ctl      (w_ctl),
        .o_resp     (w_resp)
    );

    // row of cells, each linked to its lower and upper neighbor
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_below;
        logic [DATA_WIDTH-1:0] w_above;
        if (k == 0) begin : g_first
            assign w_below = i_value_in;
        end else begin : g_mid_lo
            assign w_below = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_above = w_data[k];
        end else begin : g_mid_hi
            assign w_above = w_data[k+1];
        end
        birl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (i_value_in),
            .i_below (w_below),
            .i_above (w_above),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // only the addressed cell drives a nonzero tap, so an or merges them
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    // handshake state
    assign n_pend      = w_accept || (r_pend && !w_adv);
    assign n_out_valid = w_adv || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // tap stage and output word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_resp <= w_resp;
        end
        if (w_adv) begin
            r_out_resp <= r_p_resp;
            r_out_rd   <= w_rd;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_resp.status;
    assign o_read_value  = r_out_rd;
    assign o_entry_count = r_out_resp.count;
    assign o_is_full     = r_out_resp.full;
    assign o_is_empty    = r_out_resp.empty;

    `BIRL_ASSERT(a_fail_reads_zero, !(o_out_valid && (o_status != ST_OK)) || (o_read_value == '0), "failed request carries read data")
    `BIRL_ASSERT_NEXT(a_tap_stage_holds, r_pend && r_out_valid && i_out_stall, r_pend && $stable(r_p_resp), "tap stage lost a word under stall")

endmodule

// ===== rtl/core/birl_cell.sv =====
// one slot of the list: holds an entry and trades it with its neighbors
// depends on birl_pkg for the control struct
module birl_cell
    import birl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_below,
    input  logic [DATA_WIDTH-1:0] i_above,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [DATA_WIDTH-1:0] r_tap;
    logic [DATA_WIDTH-1:0] n_tap;
    logic                  w_at_pos;
    logic                  w_above_pos;

    // where this slot sits relative to the requested position
    always_comb begin
        w_at_pos    = (IDX < (2 ** POS_W)) && (int'(i_ctl.pos) == IDX);
        w_above_pos = IDX > int'(i_ctl.pos);
    end

    // insert opens a hole at the position, remove closes it
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && w_at_pos) begin
            n_data = i_value;
        end else if (i_ctl.ins && w_above_pos) begin
            n_data = i_below;
        end else if (i_ctl.rem && (w_at_pos || w_above_pos)) begin
            n_data = i_above;
        end
        n_tap = (i_ctl.rd && w_at_pos) ? r_data : '0;
    end

    // entry and read tap, payload only
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.acc) begin
            r_tap <= n_tap;
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

// ===== rtl/core/birl_ctrl.sv =====
// count and capacity registers and the per-request decision
// depends on birl_pkg and assert_macros.svh
`include "assert_macros.svh"

module birl_ctrl
    import birl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [POS_W-1:0]  i_position,
    output t_cell_ctl         o_ctl,
    output t_resp             o_resp
);

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_cap;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_new;
    t_mode            w_mode;
    t_status          w_status;

    // capacity clamped to 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CNT_W'(1);
        end else if (int'(r_cap) > DEPTH) begin
            w_cap = CNT_W'(DEPTH);
        end else begin
            w_cap = r_cap;
        end
    end

    assign w_pos  = CNT_W'(i_position);
    assign w_mode = t_mode'(i_mode);

    // status and next count; full is checked before position on insert,
    // empty before position on remove
    always_comb begin
        w_status = ST_OK;
        w_new    = r_count;
        case (w_mode)
            MODE_INSERT: begin
                if (r_count >= w_cap) begin
                    w_status = ST_FULL;
                end else if (w_pos > r_count) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_new = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= r_count) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_new = r_count - CNT_W'(1);
                end
            end
            MODE_READ: begin
                if (w_pos >= r_count) begin
                    w_status = ST_BAD_POS;
                end
            end
            MODE_CLEAR: begin
                w_new = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // commands to the cell chain: insert, remove and read only for accepted words that succeed
    always_comb begin
        o_ctl.acc = i_accept;
        o_ctl.ins = i_accept && (w_mode == MODE_INSERT) && (w_status == ST_OK);
        o_ctl.rem = i_accept && (w_mode == MODE_REMOVE) && (w_status == ST_OK);
        o_ctl.rd  = i_accept && (w_mode == MODE_READ) && (w_status == ST_OK);
        o_ctl.pos = i_position;
    end

    always_comb begin
        o_resp.status = w_status;
        o_resp.count  = w_new;
        o_resp.full   = w_new >= w_cap;
        o_resp.empty  = w_new == '0;
    end

    assign n_count = i_accept ? w_new : r_count;

    // count and capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    `BIRL_ASSERT_NEXT(a_insert_counts_up, o_ctl.ins, r_count == $past(r_count) + CNT_W'(1), "insert did not advance the count")
    `BIRL_ASSERT_NEXT(a_clear_empties, i_accept && (w_mode == MODE_CLEAR), r_count == '0, "clear left entries behind")

endmodule

// ===== test/bounded_insert_remove_list_top_tb.sv =====
// self-checking testbench for bounded_insert_remove_list_top: directed table, then random phases
// predicts unpinned result words from its copy of the list; depends on birl_pkg and the rtl
module bounded_insert_remove_list_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import birl_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int LATENCY    = 2;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 80;
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    // capacity, sender idle percent, receiver stall percent, insert percent per phase
    localparam int PHASE_CAP  [PHASES] = '{64, 64, 1, 8, 127, 0, 3, 64};
    localparam int PHASE_SEND [PHASES] = '{0, 56, 0, 37, 0, 56, 0, 37};
    localparam int PHASE_RECV [PHASES] = '{0, 0, 56, 37, 0, 0, 56, 37};
    localparam int PHASE_INS  [PHASES] = '{60, 45, 40, 45, 70, 40, 50, 50};

    typedef struct packed {
        t_status          status;
        logic [31:0]      rd;
        logic [CNT_W-1:0] cnt;
        logic             full;
        logic             empty;
    } list_result_t;

    typedef struct packed {
        logic             set_cap;
        logic [CNT_W-1:0] cap;
        t_mode            mode;
        logic [POS_W-1:0] pos;
        logic [31:0]      val;
        logic             pinned;
        list_result_t     res;
    } script_row_t;

    localparam list_result_t NO_PIN = '0;
    localparam int SCRIPT_LEN = 25;

    // directed walk; pinned rows carry the result read straight off the spec
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, 7'd0, MODE_READ,   6'd0,  32'h0000_0000, 1'b1,
          '{ST_BAD_POS, 32'd0, 7'd0, 1'b0, 1'b1}},
        '{1'b0, 7'd0, MODE_REMOVE, 6'd0,  32'h0000_0000, 1'b1,
          '{ST_EMPTY, 32'd0, 7'd0, 1'b0, 1'b1}},
        '{1'b0, 7'd0, MODE_REMOVE, 6'd63, 32'hffff_ffff, 1'b1,
          '{ST_EMPTY, 32'd0, 7'd0, 1'b0, 1'b1}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd1,  32'h0000_0005, 1'b1,
          '{ST_BAD_POS, 32'd0, 7'd0, 1'b0, 1'b1}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd0,  32'h7fff_ffff, 1'b1,
          '{ST_OK, 32'd0, 7'd1, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd0,  32'h8000_0000, 1'b1,
          '{ST_OK, 32'd0, 7'd2, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd2,  32'hffff_ffff, 1'b1,
          '{ST_OK, 32'd0, 7'd3, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd1,  32'h5555_5555, 1'b1,
          '{ST_OK, 32'd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_READ,   6'd0,  32'h0000_0000, 1'b0, NO_PIN},
        '{1'b0, 7'd0, MODE_READ,   6'd3,  32'h0000_0000, 1'b0, NO_PIN},
        '{1'b0, 7'd0, MODE_READ,   6'd4,  32'h0000_0000, 1'b1,
          '{ST_BAD_POS, 32'd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd63, 32'h1234_5678, 1'b1,
          '{ST_BAD_POS, 32'd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_REMOVE, 6'd4,  32'h0000_0000, 1'b1,
          '{ST_BAD_POS, 32'd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_REMOVE, 6'd1,  32'h0000_0000, 1'b0, NO_PIN},
        '{1'b0, 7'd0, MODE_READ,   6'd1,  32'h0000_0000, 1'b0, NO_PIN},
        '{1'b0, 7'd0, MODE_REMOVE, 6'd2,  32'h0000_0000, 1'b0, NO_PIN},
        '{1'b0, 7'd0, MODE_CLEAR,  6'd63, 32'haaaa_aaaa, 1'b1,
          '{ST_OK, 32'd0, 7'd0, 1'b0, 1'b1}},
        '{1'b0, 7'd0, MODE_CLEAR,  6'd0,  32'h0000_0000, 1'b1,
          '{ST_OK, 32'd0, 7'd0, 1'b0, 1'b1}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd0,  32'haaaa_aaaa, 1'b1,
          '{ST_OK, 32'd0, 7'd1, 1'b0, 1'b0}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd1,  32'h1234_5678, 1'b1,
          '{ST_OK, 32'd0, 7'd2, 1'b0, 1'b0}},
        // capacity lowered below the count: inserts see full
        '{1'b1, 7'd1, MODE_INSERT, 6'd0,  32'h0000_0001, 1'b1,
          '{ST_FULL, 32'd0, 7'd2, 1'b1, 1'b0}},
        '{1'b0, 7'd0, MODE_READ,   6'd1,  32'h0000_0000, 1'b0, NO_PIN},
        // capacity zero acts as one
        '{1'b1, 7'd0, MODE_REMOVE, 6'd0,  32'h0000_0000, 1'b1,
          '{ST_OK, 32'd0, 7'd1, 1'b1, 1'b0}},
        '{1'b0, 7'd0, MODE_INSERT, 6'd0,  32'h0000_0002, 1'b1,
          '{ST_FULL, 32'd0, 7'd1, 1'b1, 1'b0}},
        // capacity above the depth acts as the depth
        '{1'b1, 7'd127, MODE_INSERT, 6'd1, 32'hdead_beef, 1'b1,
          '{ST_OK, 32'd0, 7'd2, 1'b0, 1'b0}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CNT_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [MODE_W-1:0]     i_mode;
    logic [POS_W-1:0]      i_position;
    logic signed [31:0]    i_value_in;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ST_W-1:0]       o_status;
    logic signed [31:0]    o_read_value;
    logic [CNT_W-1:0]      o_entry_count;
    logic                  o_is_full;
    logic                  o_is_empty;

    // pinned expectation travels with the input word
    logic                  row_pinned;
    list_result_t          row_result;

    // list shadow and expected result words
    logic [31:0]           slots [64];
    int                    list_count;
    int                    cap_reg;
    list_result_t          expected_words [$];
    int                    mismatches = 0;
    int                    send_pct = 0;
    int                    recv_pct = 0;

    bounded_insert_remove_list_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // list behavior for one request, updates the shadow
    function automatic list_result_t apply_request(t_mode m, int p, logic [31:0] v);
        list_result_t r;
        int lim;
        lim = (cap_reg < 1) ? 1 : (cap_reg > 64) ? 64 : cap_reg;
        r = '0;
        r.status = ST_OK;
        case (m)
            MODE_INSERT: begin
                if (list_count >= lim) begin
                    r.status = ST_FULL;
                end else if (p > list_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int i = list_count; i > p; i--) slots[i] = slots[i-1];
                    slots[p] = v;
                    list_count++;
                end
            end
            MODE_REMOVE: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= list_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int i = p; i + 1 < list_count; i++) slots[i] = slots[i+1];
                    list_count--;
                end
            end
            MODE_READ: begin
                if (p >= list_count) r.status = ST_BAD_POS;
                else r.rd = slots[p];
            end
            default: begin
                list_count = 0;
            end
        endcase
        r.cnt   = list_count[CNT_W-1:0];
        r.full  = (list_count >= lim);
        r.empty = (list_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
        mismatches++;
    endtask

    // check result words, predict accepted words, then track config writes
    always @(posedge i_clk) begin : monitor
        list_result_t seen;
        list_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < 64; i++) slots[i] = '0;
            list_count = 0;
            cap_reg = int'(CAP_RESET);
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen = '{t_status'(o_status), o_read_value, o_entry_count, o_is_full,
                         o_is_empty};
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, count", 32'(seen.cnt), 32'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch("status", 32'(seen.status), 32'(want.status));
                    if (seen.rd !== want.rd)
                        report_mismatch("read_value", seen.rd, want.rd);
                    if (seen.cnt !== want.cnt)
                        report_mismatch("entry_count", 32'(seen.cnt), 32'(want.cnt));
                    if (seen.full !== want.full)
                        report_mismatch("is_full", 32'(seen.full), 32'(want.full));
                    if (seen.empty !== want.empty)
                        report_mismatch("is_empty", 32'(seen.empty), 32'(want.empty));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = apply_request(t_mode'(i_mode), int'(i_position), i_value_in);
                if (row_pinned) want = row_result;
                expected_words.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) cap_reg = int'(i_cfg_data);
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_pct);
    end

    // offer one word, with random idle cycles ahead of it, and hold until taken
    task automatic send_word(input t_mode m, input logic [POS_W-1:0] p,
                             input logic [31:0] v, input logic pin,
                             input list_result_t res);
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_position <= p;
        i_value_in <= v;
        row_pinned <= pin;
        row_result <= res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_mode m;
        int r;
        int hi;
        logic [POS_W-1:0] p;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_READ;
        i_position  = '0;
        i_value_in  = '0;
        row_pinned  = 1'b0;
        row_result  = NO_PIN;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < SCRIPT_LEN; k++) begin
            if (SCRIPT[k].set_cap) begin
                go_idle();
                wait_drained();
                set_capacity(SCRIPT[k].cap);
            end
            send_word(SCRIPT[k].mode, SCRIPT[k].pos, SCRIPT[k].val, SCRIPT[k].pinned,
                      SCRIPT[k].res);
        end
        go_idle();

        // random phases, mostly in-range positions so the list fills and drains
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            set_capacity(PHASE_CAP[ph][CNT_W-1:0]);
            send_pct = PHASE_SEND[ph];
            recv_pct = PHASE_RECV[ph];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) begin
                    // hold off until the list core has answered everything
                    go_idle();
                    wait_drained();
                end
                r = $urandom_range(99);
                if (r < 3) m = MODE_CLEAR;
                else if (r < 3 + PHASE_INS[ph]) m = MODE_INSERT;
                else if (r < 3 + PHASE_INS[ph] + (97 - PHASE_INS[ph]) / 2) m = MODE_REMOVE;
                else m = MODE_READ;
                hi = (m == MODE_INSERT) ? list_count : list_count - 1;
                if (hi > 63) hi = 63;
                if (hi >= 0 && $urandom_range(99) < 85) p = POS_W'($urandom_range(hi, 0));
                else p = POS_W'($urandom_range(63));
                send_word(m, p, $urandom, 1'b0, NO_PIN);
            end
            go_idle();
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("bounded_insert_remove_list_top regression: pass");
        end else begin
            $display("bounded_insert_remove_list_top regression: fail");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("bounded_insert_remove_list_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/birl_pkg.sv
rtl/core/birl_cell.sv
rtl/core/birl_ctrl.sv
rtl/core/bounded_insert_remove_list_top.sv
test/bounded_insert_remove_list_top_tb.sv
